// ===== hdl/bdq_pkg.sv =====
// Shared constants and operation/status codes for the bounded deque.
package bdq_pkg;

    // Payload widths
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Default number of stored words
    localparam int DEPTH_DEFAULT = 16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CONTAINS   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== hdl/bdq_if.sv =====
// Request and response channel interfaces of the bounded deque.
interface bdq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [bdq_pkg::FUNC_W-1:0]    func;
    logic signed [bdq_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [bdq_pkg::STATUS_W-1:0]  status;
    logic                                 found;
    logic signed [bdq_pkg::VALUE_W-1:0]   removed_word;
    logic        [bdq_pkg::COUNT_W-1:0]   entry_count;
    logic                                 is_empty;
    logic                                 is_full;

    modport source (output valid, output status, output found, output removed_word,
                    output entry_count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input found, input removed_word,
                    input entry_count, input is_empty, input is_full, output ready);
endinterface

// ===== hdl/bounded_deque_with_search_top.sv =====
// Bounded deque of signed words in a ring-buffer memory, with key search.
//
// Usage:
//   req carries one request: func (push front, push back, pop front,
//   pop back, contains) and value (word to push or key to search for).
//   rsp returns one response per request: status, found, removed_word,
//   entry_count, is_empty and is_full after the request took effect.
// Timing:
//   One request is in work at a time; req.ready is high while the block
//   waits for a request. The memory read is registered.
//   Push, rejected push, ignored pop, search of an empty store and
//   unknown codes go from idle straight to loading the response. Pop
//   reads the word first. Contains compares one entry per cycle from
//   the front until a match or the last entry, then loads the response.
//   The next request is taken as soon as the response has been loaded.
// Reset:
//   rst_n clears the count, the front pointer and the response valid.
//   Memory contents are not cleared; no clearing pass is needed.
// Stall:
//   A response waits in the output register while rsp.ready is low; the
//   block accepts one more request and holds its response until free.
module bounded_deque_with_search_top #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    bdq_req_if.sink       req,
    bdq_rsp_if.source     rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    // Ring position helpers
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    // base + off with off below DEPTH, so one subtract wraps it
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= DEPTH_SUM)
        begin
            sum = sum - DEPTH_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t                               state_reg, state_next;
    logic        [IDX_W-1:0]              front_reg, front_next;
    logic        [CNT_W-1:0]              occ_reg, occ_next;
    logic        [IDX_W-1:0]              scan_addr_reg, scan_addr_next;
    logic        [CNT_W-1:0]              scan_left_reg, scan_left_next;
    logic signed [bdq_pkg::VALUE_W-1:0]   key_reg, key_next;
    logic        [bdq_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                                 res_found_reg, res_found_next;
    logic signed [bdq_pkg::VALUE_W-1:0]   res_removed_reg, res_removed_next;

    logic                                 out_valid_reg, out_valid_next;
    logic        [bdq_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic                                 out_found_reg, out_found_next;
    logic signed [bdq_pkg::VALUE_W-1:0]   out_removed_reg, out_removed_next;
    logic        [bdq_pkg::COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                                 out_empty_reg, out_empty_next;
    logic                                 out_full_reg, out_full_next;

    // Memory port signals
    logic                                 mem_we;
    logic        [IDX_W-1:0]              mem_waddr;
    logic signed [bdq_pkg::VALUE_W-1:0]   mem_wdata;
    logic                                 mem_re;
    logic        [IDX_W-1:0]              mem_raddr;
    logic signed [bdq_pkg::VALUE_W-1:0]   rd_data_reg;
    logic        [bdq_pkg::VALUE_W-1:0]   mem [DEPTH];

    logic                                 is_full_now;
    logic                                 is_empty_now;
    logic                                 out_free;

    assign is_full_now  = (occ_reg == FULL_CNT);
    assign is_empty_now = (occ_reg == '0);
    assign out_free     = !out_valid_reg || rsp.ready;
    assign req.ready    = (state_reg == S_IDLE);

    // Word store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        occ_next         = occ_reg;
        scan_addr_next   = scan_addr_reg;
        scan_left_next   = scan_left_reg;
        key_next         = key_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        res_removed_next = res_removed_reg;

        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;
        out_empty_next   = out_empty_reg;
        out_full_next    = out_full_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = req.value;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next  = bdq_pkg::ST_DONE;
                    res_found_next   = 1'b0;
                    res_removed_next = '0;
                    state_next       = S_EMIT;
                    unique case (req.func)
                        bdq_pkg::FN_PUSH_FRONT:
                        begin
                            if (is_full_now)
                            begin
                                res_status_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = idx_dec(front_reg);
                                front_next = idx_dec(front_reg);
                                occ_next   = occ_reg + 1'b1;
                            end
                        end
                        bdq_pkg::FN_PUSH_BACK:
                        begin
                            if (is_full_now)
                            begin
                                res_status_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_add(front_reg, occ_reg);
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        bdq_pkg::FN_POP_FRONT:
                        begin
                            if (is_empty_now)
                            begin
                                res_status_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = front_reg;
                                front_next = idx_inc(front_reg);
                                occ_next   = occ_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        bdq_pkg::FN_POP_BACK:
                        begin
                            if (is_empty_now)
                            begin
                                res_status_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_add(front_reg, occ_reg - 1'b1);
                                occ_next   = occ_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        bdq_pkg::FN_CONTAINS:
                        begin
                            key_next = req.value;
                            if (!is_empty_now)
                            begin
                                mem_re         = 1'b1;
                                mem_raddr      = front_reg;
                                scan_addr_next = idx_inc(front_reg);
                                scan_left_next = occ_reg - 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // unused codes: no operation
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_removed_next = rd_data_reg;
                state_next       = S_EMIT;
            end
            S_SCAN:
            begin
                // rd_data_reg holds the entry read in the previous cycle
                if (rd_data_reg == key_reg)
                begin
                    res_found_next = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (scan_left_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_addr_reg;
                    scan_addr_next = idx_inc(scan_addr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_found_next   = res_found_reg;
                    out_removed_next = res_removed_reg;
                    out_count_next   = bdq_pkg::COUNT_W'(occ_reg);
                    out_empty_next   = is_empty_now;
                    out_full_next    = is_full_now;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            scan_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            scan_left_reg <= scan_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_addr_reg   <= scan_addr_next;
        key_reg         <= key_next;
        res_status_reg  <= res_status_next;
        res_found_reg   <= res_found_next;
        res_removed_reg <= res_removed_next;
        out_status_reg  <= out_status_next;
        out_found_reg   <= out_found_next;
        out_removed_reg <= out_removed_next;
        out_count_reg   <= out_count_next;
        out_empty_reg   <= out_empty_next;
        out_full_reg    <= out_full_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.removed_word = out_removed_reg;
    assign rsp.entry_count  = out_count_reg;
    assign rsp.is_empty     = out_empty_reg;
    assign rsp.is_full      = out_full_reg;

`ifndef ASSERT_OFF
    // Occupancy never passes the store size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_CNT)
        else $error("occupancy above depth");

    // A push on a full store leaves the occupancy alone
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && is_full_now &&
         (req.func == bdq_pkg::FN_PUSH_FRONT || req.func == bdq_pkg::FN_PUSH_BACK))
        |=> $stable(occ_reg))
        else $error("push on full changed occupancy");

    // The search never runs past the stored entries
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_left_reg < occ_reg))
        else $error("search beyond stored entries");

    // Reads and writes of the store never share a cycle
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store read and write in one cycle");

    // A response is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && !rsp.ready) |=> (state_reg == S_EMIT))
        else $error("response loaded over a pending one");
`endif

endmodule

// ===== test/bounded_deque_with_search_top_tb.sv =====
// Self-checking testbench for the bounded deque with key search.
`timescale 1ns / 1ps

module bounded_deque_with_search_top_tb;

    localparam int FUNC_W         = bdq_pkg::FUNC_W;
    localparam int VALUE_W        = bdq_pkg::VALUE_W;
    localparam int STATUS_W       = bdq_pkg::STATUS_W;
    localparam int COUNT_W        = bdq_pkg::COUNT_W;
    localparam int DEPTH          = bdq_pkg::DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = DEPTH + 8;
    localparam int RESET_CYCLES   = 12;

    localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

    // One response as the deque reports it
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      found;
        logic signed [VALUE_W-1:0] removed_word;
        logic [COUNT_W-1:0]        entry_count;
        logic                      is_empty;
        logic                      is_full;
    } deque_rsp_t;

    logic clk;
    logic rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_search_top #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the deque contents
    logic signed [VALUE_W-1:0] shadow_ring [DEPTH];
    int                        shadow_head;
    int                        shadow_count;

    deque_rsp_t pending_results [$];
    int         fails;
    int         quiet_cycles;
    int         req_idle_pct;
    int         rsp_stall_pct;

    always #1 clk = ~clk;

    // Apply one request to the shadow deque and queue the response it should give
    function automatic void apply_deque_op(input logic [FUNC_W-1:0] op,
                                           input logic signed [VALUE_W-1:0] word);
        deque_rsp_t e;
        int         i;
        e = '0;
        unique case (op)
            bdq_pkg::FN_PUSH_FRONT:
            begin
                if (shadow_count >= DEPTH)
                    e.status = bdq_pkg::ST_FULL;
                else
                begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_head] = word;
                    shadow_count++;
                end
            end
            bdq_pkg::FN_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                    e.status = bdq_pkg::ST_FULL;
                else
                begin
                    shadow_ring[(shadow_head + shadow_count) % DEPTH] = word;
                    shadow_count++;
                end
            end
            bdq_pkg::FN_POP_FRONT:
            begin
                if (shadow_count == 0)
                    e.status = bdq_pkg::ST_EMPTY;
                else
                begin
                    e.removed_word = shadow_ring[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
            end
            bdq_pkg::FN_POP_BACK:
            begin
                if (shadow_count == 0)
                    e.status = bdq_pkg::ST_EMPTY;
                else
                begin
                    e.removed_word = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
                    shadow_count--;
                end
            end
            bdq_pkg::FN_CONTAINS:
            begin
                for (i = 0; i < shadow_count; i++)
                    if (shadow_ring[(shadow_head + i) % DEPTH] == word)
                        e.found = 1'b1;
            end
            default:
            begin
                // unused codes leave the deque alone
            end
        endcase
        e.entry_count = COUNT_W'(shadow_count);
        e.is_empty    = (shadow_count == 0);
        e.is_full     = (shadow_count == DEPTH);
        pending_results.insert(pending_results.size(), e);
    endfunction

    task automatic note_mismatch(input string field, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
        $display("%0t: %s mismatch: expected 'h%h, got 'h%h", $time, field, want, got);
        fails++;
    endtask

    // Response checker and receiver-side stall
    always @(posedge clk)
    begin
        deque_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, got status %0d count %0d",
                         $time, rsp_ch.status, rsp_ch.entry_count);
                fails++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (rsp_ch.status !== want.status)
                    note_mismatch("status", VALUE_W'(want.status), VALUE_W'(rsp_ch.status));
                if (rsp_ch.found !== want.found)
                    note_mismatch("found", VALUE_W'(want.found), VALUE_W'(rsp_ch.found));
                if (rsp_ch.removed_word !== want.removed_word)
                    note_mismatch("removed_word", want.removed_word, rsp_ch.removed_word);
                if (rsp_ch.entry_count !== want.entry_count)
                    note_mismatch("entry_count", VALUE_W'(want.entry_count),
                                  VALUE_W'(rsp_ch.entry_count));
                if (rsp_ch.is_empty !== want.is_empty)
                    note_mismatch("is_empty", VALUE_W'(want.is_empty),
                                  VALUE_W'(rsp_ch.is_empty));
                if (rsp_ch.is_full !== want.is_full)
                    note_mismatch("is_full", VALUE_W'(want.is_full), VALUE_W'(rsp_ch.is_full));
            end
        end
        rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Send one request; valid stays high on return unless the next call idles
    task automatic send_request(input logic [FUNC_W-1:0] op,
                                input logic signed [VALUE_W-1:0] word);
        while (req_idle_pct != 0 && $urandom_range(99, 0) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.value <= word;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_deque_op(op, word);
    endtask

    // Hold off new requests until every queued response is back
    task automatic wait_for_responses();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Words biased toward extremes and a small pool so searches hit duplicates
    function automatic logic signed [VALUE_W-1:0] random_word();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 4)
            return WORD_MAX;
        else if (pick < 8)
            return WORD_MIN;
        else if (pick < 12)
            return -1;
        else if (pick < 30)
            return VALUE_W'($urandom_range(7, 0));
        else
            return VALUE_W'($urandom);
    endfunction

    // Random mix; the push share swings to walk the deque between empty and full
    task automatic run_random(input int count, input int sender_pct, input int receiver_pct,
                              input bit pause_midway);
        int                        pick;
        int                        push_pct;
        logic [FUNC_W-1:0]         op;
        logic signed [VALUE_W-1:0] word;
        req_idle_pct  = sender_pct;
        rsp_stall_pct = receiver_pct;
        for (int n = 0; n < count; n++)
        begin
            if (pause_midway && n == count / 2)
                wait_for_responses();
            push_pct = ((n / 30) % 2 == 0) ? 85 : 15;
            pick = $urandom_range(99, 0);
            word = random_word();
            if (pick < 4)
                op = FUNC_W'($urandom_range(2 ** FUNC_W - 1, bdq_pkg::FN_CONTAINS + 1));
            else if (pick < 20)
            begin
                op = bdq_pkg::FN_CONTAINS;
                if (shadow_count > 0 && $urandom_range(99, 0) < 60)
                    word = shadow_ring[(shadow_head + $urandom_range(shadow_count - 1, 0))
                                       % DEPTH];
            end
            else if ($urandom_range(99, 0) < push_pct)
                op = $urandom_range(1, 0) ? bdq_pkg::FN_PUSH_FRONT : bdq_pkg::FN_PUSH_BACK;
            else
                op = $urandom_range(1, 0) ? bdq_pkg::FN_POP_FRONT : bdq_pkg::FN_POP_BACK;
            send_request(op, word);
        end
    endtask

    // Empty-deque cases, unused codes, word extremes, search hits and misses
    task automatic test_directed();
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        send_request(bdq_pkg::FN_POP_FRONT, 0);
        send_request(bdq_pkg::FN_POP_BACK, 0);
        send_request(bdq_pkg::FN_CONTAINS, 0);
        for (int code = bdq_pkg::FN_CONTAINS + 1; code < 2 ** FUNC_W; code++)
            send_request(FUNC_W'(code), WORD_MAX);
        send_request(bdq_pkg::FN_PUSH_FRONT, WORD_MAX);
        send_request(bdq_pkg::FN_PUSH_BACK, WORD_MIN);
        send_request(bdq_pkg::FN_PUSH_FRONT, 0);
        send_request(bdq_pkg::FN_PUSH_BACK, -1);
        send_request(bdq_pkg::FN_CONTAINS, WORD_MIN);
        send_request(bdq_pkg::FN_CONTAINS, -1);
        send_request(bdq_pkg::FN_CONTAINS, 0);
        send_request(bdq_pkg::FN_CONTAINS, 32'sd12345);
        send_request(FUNC_W'(bdq_pkg::FN_CONTAINS + 1), -1);
        send_request(bdq_pkg::FN_POP_FRONT, 0);
        send_request(bdq_pkg::FN_POP_BACK, 0);
        send_request(bdq_pkg::FN_POP_FRONT, 0);
        send_request(bdq_pkg::FN_POP_BACK, 0);
        send_request(bdq_pkg::FN_POP_BACK, 0);
    endtask

    task automatic test_back_to_back();
        run_random(100, 0, 0, 1'b0);
    endtask

    task automatic test_sparse_requests();
        run_random(100, 82, 0, 1'b0);
    endtask

    task automatic test_slow_consumer();
        run_random(100, 0, 82, 1'b0);
    endtask

    task automatic test_mixed_idle_with_pause();
        run_random(100, 15, 15, 1'b1);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.func   = bdq_pkg::FN_PUSH_FRONT;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        fails         = 0;
        quiet_cycles  = 0;
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        shadow_head   = 0;
        shadow_count  = 0;
        foreach (shadow_ring[k])
            shadow_ring[k] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back();
        test_sparse_requests();
        test_slow_consumer();
        test_mixed_idle_with_pause();

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fails == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== bounded_deque_with_search_top.f =====
hdl/bdq_pkg.sv
hdl/bdq_if.sv
hdl/bounded_deque_with_search_top.sv
test/bounded_deque_with_search_top_tb.sv
